[src/mlp_three_layer_classifier_unit_macros.svh]
// assertion helpers shared by the classifier rtl
// both expect clk_i and rst_ni in scope
`ifndef MLP_THREE_LAYER_CLASSIFIER_UNIT_MACROS_SVH
`define MLP_THREE_LAYER_CLASSIFIER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MTL_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("same-cycle check failed");
`define MTL_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define MTL_ASSERT_IMP(lbl, a, c)
`define MTL_ASSERT_NXT(lbl, a, c)
`endif
`endif

[src/mtl_pkg.sv]
package mtl_pkg;

  localparam int IDX_W   = 6;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 48;
  localparam int GAIN_W  = 15;
  localparam int HID_W   = 15;
  localparam int TAB_LEN = 1024;
  localparam int TAB_AW  = 10;
  localparam int SHIFT_H1 = 30;
  localparam int SHIFT_H2 = 33;

  localparam int DEF_IN_SIZE   = 64;
  localparam int DEF_HID1_SIZE = 32;
  localparam int DEF_HID2_SIZE = 32;
  localparam int DEF_OUT_SIZE  = 8;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380001;

  // layer codes
  localparam logic [1:0] LYR_IN = 2'd0;
  localparam logic [1:0] LYR_H1 = 2'd1;
  localparam logic [1:0] LYR_H2 = 2'd2;

  // request kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FEAT = 1'b1;

  typedef enum logic [2:0] {S_IDLE, S_FEED, S_WAIT, S_DRAIN, S_SETTLE} state_e;

  // one vector element moving down the cell row
  typedef struct packed {
    logic                    v;
    logic [1:0]              layer;
    logic [IDX_W-1:0]        idx;
    logic                    first;
    logic                    last;
    logic signed [VAL_W-1:0] x;
  } tok_t;

  // weight write broadcast to every cell
  typedef struct packed {
    logic                    en;
    logic [1:0]              layer;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } wr_t;

  typedef logic [HID_W-1:0] sig_tab_t [TAB_LEN];

  // sigmoid table, Q0.15, index i covers (i-512)/64
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t    t;
    logic [63:0] pw [513];
    logic [63:0] p;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    int          k;
    p = 64'd1 << 32;
    pw[0] = p;
    for (int m = 1; m <= 512; m++) begin
      p = (p * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
      pw[m] = p;
    end
    for (int m = 0; m < TAB_LEN; m++) begin
      k = m - 512;
      e = pw[(k < 0) ? -k : k];
      d = (64'd1 << 32) + e;
      num = (k >= 0) ? (64'd1 << 47) : (e << 15);
      num = num + (d >> 1);
      // long division, elaboration only
      rem = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem = rem - d;
          q[b] = 1'b1;
        end
      end
      if (q > 64'd32767) q = 64'd32767;
      t[m] = q[HID_W-1:0];
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

[src/mtl_cell.sv]
module mtl_cell #(
  parameter int CELL_IDX  = 0,
  parameter int IN_SIZE   = 64,
  parameter int HID1_SIZE = 32,
  parameter int HID2_SIZE = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mtl_pkg::tok_t                tok_i,
  output mtl_pkg::tok_t                tok_o,
  input  mtl_pkg::wr_t                 wr_i,
  input  logic [mtl_pkg::IDX_W:0]      n_rows_i,
  input  logic                         shift_i,
  input  logic                         slot_nxt_v_i,
  input  logic [mtl_pkg::ACC_W-1:0]    slot_nxt_i,
  output logic                         slot_v_o,
  output logic [mtl_pkg::ACC_W-1:0]    slot_o
);
  import mtl_pkg::*;

  localparam int A1 = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int A2 = (HID1_SIZE > 1) ? $clog2(HID1_SIZE) : 1;
  localparam int A3 = (HID2_SIZE > 1) ? $clog2(HID2_SIZE) : 1;

  // this cell's weight rows, one per layer
  logic signed [VAL_W-1:0] mem1 [IN_SIZE];
  logic signed [VAL_W-1:0] mem2 [HID1_SIZE];
  logic signed [VAL_W-1:0] mem3 [HID2_SIZE];

  logic signed [VAL_W-1:0]  w1_q, w2_q, w3_q, w;
  tok_t                     tok_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     s1_v_q, s1_first_q, s1_last_q;
  logic signed [ACC_W-1:0]  acc_q, sum;
  logic                     inject;
  logic                     slot_v_q;
  logic [ACC_W-1:0]         slot_q;

  // weight writes addressed to this row
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.row == IDX_W'(CELL_IDX)) begin
      case (wr_i.layer)
        LYR_IN:  mem1[wr_i.col[A1-1:0]] <= wr_i.value;
        LYR_H1:  mem2[wr_i.col[A2-1:0]] <= wr_i.value;
        LYR_H2:  mem3[wr_i.col[A3-1:0]] <= wr_i.value;
        default: ;
      endcase
    end
  end

  // weight read lined up with the element
  always_ff @(posedge clk_i) begin
    w1_q <= mem1[tok_i.idx[A1-1:0]];
    w2_q <= mem2[tok_i.idx[A2-1:0]];
    w3_q <= mem3[tok_i.idx[A3-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign tok_o = tok_q;

  always_comb begin
    case (tok_q.layer)
      LYR_IN:  w = w1_q;
      LYR_H1:  w = w2_q;
      default: w = w3_q;
    endcase
  end

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= tok_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= w * tok_q.x;
    s1_first_q <= tok_q.first;
    s1_last_q  <= tok_q.last;
  end

  // accumulate, first element restarts the sum
  assign sum = s1_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
  assign inject = s1_v_q && s1_last_q && ((IDX_W + 1)'(CELL_IDX) < n_rows_i);

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      acc_q <= sum;
    end
  end

  // result slot, shifts toward cell zero while draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q <= 1'b0;
    end else if (inject) begin
      slot_v_q <= 1'b1;
    end else if (shift_i) begin
      slot_v_q <= slot_nxt_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (inject) begin
      slot_q <= sum;
    end else if (shift_i) begin
      slot_q <= slot_nxt_i;
    end
  end

  assign slot_v_o = slot_v_q;
  assign slot_o   = slot_q;

endmodule

[src/mtl_act.sv]
module mtl_act (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        v_i,
  input  logic [mtl_pkg::ACC_W-1:0]   acc_i,
  input  logic [mtl_pkg::IDX_W-1:0]   idx_i,
  input  logic                        sel_i,
  input  logic [mtl_pkg::GAIN_W-1:0]  gain_i,
  output logic                        v_o,
  output logic [mtl_pkg::IDX_W-1:0]   idx_o,
  output logic                        sel_o,
  output logic [mtl_pkg::HID_W-1:0]   hid_o
);
  import mtl_pkg::*;

  localparam int X_W = ACC_W + GAIN_W + 1;

  logic signed [X_W-1:0]  x_q, sh;
  logic                   v1_q, v2_q, sel1_q, sel2_q;
  logic [IDX_W-1:0]       idx1_q, idx2_q;
  logic [TAB_AW-1:0]      ti;
  logic [HID_W-1:0]       hid_q;

  // gain times dot product
  always_ff @(posedge clk_i) begin
    x_q <= $signed({{(ACC_W - GAIN_W + 1){1'b0}}, gain_i})
         * $signed({{(GAIN_W + 1){acc_i[ACC_W-1]}}, acc_i});
    idx1_q <= idx_i;
    sel1_q <= sel_i;
  end

  // table index with saturation at both ends
  always_comb begin
    sh = sel1_q ? (x_q >>> SHIFT_H2) : (x_q >>> SHIFT_H1);
    if (sh < -X_W'(512)) begin
      ti = '0;
    end else if (sh > X_W'(511)) begin
      ti = '1;
    end else begin
      ti = {~sh[TAB_AW-1], sh[TAB_AW-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    hid_q  <= SIG_TAB[ti];
    idx2_q <= idx1_q;
    sel2_q <= sel1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v_i;
      v2_q <= v1_q;
    end
  end

  assign v_o   = v2_q;
  assign idx_o = idx2_q;
  assign sel_o = sel2_q;
  assign hid_o = hid_q;

endmodule

[src/mlp_three_layer_classifier_unit.sv]
// Three-layer sigmoid classifier.
// Input stream s_axis: tuser is the op (0 weight load, 1 feature), tlast closes a
// sample; tdata carries layer, row, col and the Q4.12 value. A weight request
// or a feature request without tlast is taken while the block is idle. A feature
// with tlast runs the network: each layer streams its input vector, one element a
// cycle, down a row of max(HID1,HID2,OUT) multiply-accumulate cells, one cell per
// unit; the sums then shift out of the row one a cycle, through the sigmoid unit
// for the hidden layers and into the output register for the last layer, where a
// stalled receiver can pause them. After a feature with tlast the input stays
// stalled until the last output sum has shifted out of the cell row.
// Output stream m_axis: OUT_SIZE results in unit order, tlast on the final one.
// A stalled receiver holds the output register and pauses the final drain.
// Config channel cfg writes the 15-bit sigmoid gain; write it only when idle.
// Reset restores gain 4096 and idles the block; weight and vector stores are
// not cleared and must be written before use.
module mlp_three_layer_classifier_unit #(
  parameter int IN_SIZE   = mtl_pkg::DEF_IN_SIZE,
  parameter int HID1_SIZE = mtl_pkg::DEF_HID1_SIZE,
  parameter int HID2_SIZE = mtl_pkg::DEF_HID2_SIZE,
  parameter int OUT_SIZE  = mtl_pkg::DEF_OUT_SIZE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // layer[1:0] row[7:2] col[13:8] value[29:14]
  input  logic                        s_axis_tuser,  // op
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // class_bit[0] out_index[6:1]
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mtl_pkg::GAIN_W-1:0]  cfg_data_i
);
  import mtl_pkg::*;
  `include "mlp_three_layer_classifier_unit_macros.svh"

  localparam int NC_A = (HID1_SIZE > HID2_SIZE) ? HID1_SIZE : HID2_SIZE;
  localparam int NC   = (NC_A > OUT_SIZE) ? NC_A : OUT_SIZE;
  localparam int WAIT_CYC = NC + 6;
  localparam int ACT_LAT  = 4;
  localparam int CNT_W    = ($clog2(WAIT_CYC + 1) > IDX_W) ? $clog2(WAIT_CYC + 1) : IDX_W;
  localparam int FA = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int HA1 = (HID1_SIZE > 1) ? $clog2(HID1_SIZE) : 1;
  localparam int HA2 = (HID2_SIZE > 1) ? $clog2(HID2_SIZE) : 1;

  // request fields
  logic [1:0]              in_layer;
  logic [IDX_W-1:0]        in_row, in_col;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_acc;

  assign in_layer = s_axis_tdata[1:0];
  assign in_row   = s_axis_tdata[7:2];
  assign in_col   = s_axis_tdata[13:8];
  assign in_value = s_axis_tdata[29:14];

  state_e                  state_q, state_d;
  logic [1:0]              lyr_q, lyr_d;
  logic [IDX_W-1:0]        j_q, j_d, n_in_m1;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W:0]          n_rows;
  logic                    shift;
  logic [GAIN_W-1:0]       gain_q;
  wr_t                     wr;

  // gain register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // weight write, out-of-range addresses dropped
  always_comb begin
    wr.layer = in_layer;
    wr.row   = in_row;
    wr.col   = in_col;
    wr.value = in_value;
    case (in_layer)
      LYR_IN: wr.en = ((IDX_W + 1)'(in_row) < (IDX_W + 1)'(HID1_SIZE))
                   && ((IDX_W + 1)'(in_col) < (IDX_W + 1)'(IN_SIZE));
      LYR_H1: wr.en = ((IDX_W + 1)'(in_row) < (IDX_W + 1)'(HID2_SIZE))
                   && ((IDX_W + 1)'(in_col) < (IDX_W + 1)'(HID1_SIZE));
      LYR_H2: wr.en = ((IDX_W + 1)'(in_row) < (IDX_W + 1)'(OUT_SIZE))
                   && ((IDX_W + 1)'(in_col) < (IDX_W + 1)'(HID2_SIZE));
      default: wr.en = 1'b0;
    endcase
    wr.en = wr.en && in_acc && (s_axis_tuser == OP_LOAD);
  end

  // vector stores
  logic signed [VAL_W-1:0] feat_mem [IN_SIZE];
  logic [HID_W-1:0]        h1_mem [HID1_SIZE];
  logic [HID_W-1:0]        h2_mem [HID2_SIZE];
  logic signed [VAL_W-1:0] feat_rd_q;
  logic [HID_W-1:0]        h1_rd_q, h2_rd_q;
  logic                    act_v, act_sel, act_v_o, act_sel_o;
  logic [IDX_W-1:0]        act_idx_o;
  logic [HID_W-1:0]        act_hid;

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == OP_FEAT
        && (IDX_W + 1)'(in_col) < (IDX_W + 1)'(IN_SIZE)) begin
      feat_mem[in_col[FA-1:0]] <= in_value;
    end
    if (act_v_o && !act_sel_o) begin
      h1_mem[act_idx_o[HA1-1:0]] <= act_hid;
    end
    if (act_v_o && act_sel_o) begin
      h2_mem[act_idx_o[HA2-1:0]] <= act_hid;
    end
    feat_rd_q <= feat_mem[j_q[FA-1:0]];
    h1_rd_q   <= h1_mem[j_q[HA1-1:0]];
    h2_rd_q   <= h2_mem[j_q[HA2-1:0]];
  end

  // element issue, registered alongside the store read
  logic             pv_q, pfirst_q, plast_q;
  logic [IDX_W-1:0] pidx_q;
  tok_t             chain_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= (state_q == S_FEED);
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= j_q;
    pfirst_q <= (j_q == '0);
    plast_q  <= (j_q == n_in_m1);
  end

  always_comb begin
    chain_in.v     = pv_q;
    chain_in.layer = lyr_q;
    chain_in.idx   = pidx_q;
    chain_in.first = pfirst_q;
    chain_in.last  = plast_q;
    case (lyr_q)
      LYR_IN:  chain_in.x = feat_rd_q;
      LYR_H1:  chain_in.x = $signed({1'b0, h1_rd_q});
      default: chain_in.x = $signed({1'b0, h2_rd_q});
    endcase
  end

  // sizes of the layer in progress
  always_comb begin
    case (lyr_q)
      LYR_IN: begin
        n_in_m1 = IDX_W'(IN_SIZE - 1);
        n_rows  = (IDX_W + 1)'(HID1_SIZE);
      end
      LYR_H1: begin
        n_in_m1 = IDX_W'(HID1_SIZE - 1);
        n_rows  = (IDX_W + 1)'(HID2_SIZE);
      end
      default: begin
        n_in_m1 = IDX_W'(HID2_SIZE - 1);
        n_rows  = (IDX_W + 1)'(OUT_SIZE);
      end
    endcase
  end

  // cell row
  tok_t             tok [NC+1];
  logic             slot_v [NC+1];
  logic [ACC_W-1:0] slot [NC+1];

  assign tok[0]     = chain_in;
  assign slot_v[NC] = 1'b0;
  assign slot[NC]   = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    mtl_cell #(
      .CELL_IDX (k),
      .IN_SIZE  (IN_SIZE),
      .HID1_SIZE(HID1_SIZE),
      .HID2_SIZE(HID2_SIZE)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1]),
      .wr_i        (wr),
      .n_rows_i    (n_rows),
      .shift_i     (shift),
      .slot_nxt_v_i(slot_v[k+1]),
      .slot_nxt_i  (slot[k+1]),
      .slot_v_o    (slot_v[k]),
      .slot_o      (slot[k])
    );
  end

  // sigmoid for hidden layers
  assign act_v   = shift && slot_v[0] && (lyr_q != LYR_H2);
  assign act_sel = (lyr_q == LYR_H1);

  mtl_act u_act (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .v_i   (act_v),
    .acc_i (slot[0]),
    .idx_i (cnt_q[IDX_W-1:0]),
    .sel_i (act_sel),
    .gain_i(gain_q),
    .v_o   (act_v_o),
    .idx_o (act_idx_o),
    .sel_o (act_sel_o),
    .hid_o (act_hid)
  );

  // output register
  logic             out_v_q, out_cls_q, out_last_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_load;

  assign out_load = shift && slot_v[0] && (lyr_q == LYR_H2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cls_q  <= (gain_q == '0) || !slot[0][ACC_W-1];
      out_idx_q  <= cnt_q[IDX_W-1:0];
      out_last_q <= (cnt_q == CNT_W'(OUT_SIZE - 1));
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_idx_q, out_cls_q};
  assign m_axis_tlast  = out_last_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lyr_q   <= LYR_IN;
      j_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      lyr_q   <= lyr_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    lyr_d   = lyr_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    shift   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tuser == OP_FEAT && s_axis_tlast) begin
          state_d = S_FEED;
          lyr_d   = LYR_IN;
          j_d     = '0;
        end
      end
      S_FEED: begin
        if (j_q == n_in_m1) begin
          state_d = S_WAIT;
          cnt_d   = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_WAIT: begin
        if (cnt_q == CNT_W'(WAIT_CYC - 1)) begin
          state_d = S_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        shift = (lyr_q == LYR_H2) ? (!out_v_q || m_axis_tready) : 1'b1;
        if (shift) begin
          if (cnt_q == CNT_W'(NC - 1)) begin
            cnt_d   = '0;
            state_d = (lyr_q == LYR_H2) ? S_IDLE : S_SETTLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_SETTLE: begin
        if (cnt_q == CNT_W'(ACT_LAT - 1)) begin
          state_d = S_FEED;
          lyr_d   = lyr_q + 1'b1;
          j_d     = '0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `MTL_ASSERT_IMP(a_act_in_drain, act_v_o, (state_q == S_DRAIN || state_q == S_SETTLE))
  `MTL_ASSERT_NXT(a_no_issue_idle, state_q == S_IDLE, !pv_q)
  `MTL_ASSERT_IMP(a_row_empty_feed, state_q == S_FEED, !slot_v[0])
  `MTL_ASSERT_IMP(a_out_only_last, out_load, lyr_q == LYR_H2)

endmodule

[tb/tb_mlp_three_layer_classifier_unit.sv]
`timescale 1ns / 1ps

module tb_mlp_three_layer_classifier_unit;
  import mtl_pkg::*;

  localparam int NIN   = DEF_IN_SIZE;
  localparam int NHID1 = DEF_HID1_SIZE;
  localparam int NHID2 = DEF_HID2_SIZE;
  localparam int NOUT  = DEF_OUT_SIZE;
  localparam int STALL_LIMIT = 20000;
  localparam int RX_HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 400;

  // one input request as the block sees it
  typedef struct {
    logic                    op;
    logic [1:0]              layer;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } mlp_req_t;

  // one classification result
  typedef struct {
    logic             class_bit;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
  } class_res_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [GAIN_W-1:0] cfg_data_i;

  mlp_three_layer_classifier_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state
  logic [GAIN_W-1:0]       gain_q;
  logic signed [VAL_W-1:0] wgt_in [NHID1*NIN];
  logic signed [VAL_W-1:0] wgt_h1 [NHID2*NHID1];
  logic signed [VAL_W-1:0] wgt_h2 [NOUT*NHID2];
  logic signed [VAL_W-1:0] feat_vec [NIN];
  int                      act_h1 [NHID1];
  int                      act_h2 [NHID2];
  int                      logistic_lut [TAB_LEN];

  mlp_req_t   pending_reqs[$];
  class_res_t expected_classes[$];
  int         queued_reqs;
  int         accepted_reqs;
  int         errors;
  logic       in_taken;
  logic       out_taken;
  logic       rx_hold_req;
  int         stall_cycles;

  // logistic lookup, Q0.15 over [-8,8) in steps of 1/64
  task automatic fill_logistic_lut();
    longint unsigned pw [513];
    longint unsigned p;
    longint unsigned e;
    longint unsigned d;
    longint unsigned num;
    longint unsigned v;
    int              k;
    p = 64'd1 << 32;
    pw[0] = p;
    for (int m = 1; m <= 512; m++) begin
      p = (p * 64'd4228380001 + (64'd1 << 31)) >> 32;
      pw[m] = p;
    end
    for (int m = 0; m < TAB_LEN; m++) begin
      k = m - 512;
      e = pw[(k < 0) ? -k : k];
      d = (64'd1 << 32) + e;
      num = (k >= 0) ? (64'd1 << 47) : (e << 15);
      v = (num + d / 2) / d;
      if (v > 64'd32767) v = 64'd32767;
      logistic_lut[m] = int'(v);
    end
  endtask

  function automatic int squash(longint dot, int shift);
    longint x;
    longint lim;
    x = longint'({1'b0, gain_q}) * dot;
    lim = longint'(512) <<< shift;
    if (x < -lim) return logistic_lut[0];
    if (x >= lim) return logistic_lut[TAB_LEN-1];
    return logistic_lut[int'((x + lim) >>> shift)];
  endfunction

  // apply one accepted request, queue the classes a sample produces
  task automatic classify_request(mlp_req_t r);
    longint     acc;
    class_res_t res;
    if (r.op == OP_LOAD) begin
      if (r.layer == LYR_IN && r.row < NHID1 && r.col < NIN)
        wgt_in[r.row*NIN + r.col] = r.value;
      else if (r.layer == LYR_H1 && r.row < NHID2 && r.col < NHID1)
        wgt_h1[r.row*NHID1 + r.col] = r.value;
      else if (r.layer == LYR_H2 && r.row < NOUT && r.col < NHID2)
        wgt_h2[r.row*NHID2 + r.col] = r.value;
      return;
    end
    if (r.col < NIN) feat_vec[r.col] = r.value;
    if (!r.last) return;
    for (int i = 0; i < NHID1; i++) begin
      acc = 0;
      for (int j = 0; j < NIN; j++)
        acc += longint'(wgt_in[i*NIN + j]) * longint'(feat_vec[j]);
      act_h1[i] = squash(acc, SHIFT_H1);
    end
    for (int i = 0; i < NHID2; i++) begin
      acc = 0;
      for (int j = 0; j < NHID1; j++)
        acc += longint'(wgt_h1[i*NHID1 + j]) * longint'(act_h1[j]);
      act_h2[i] = squash(acc, SHIFT_H2);
    end
    for (int i = 0; i < NOUT; i++) begin
      acc = 0;
      for (int j = 0; j < NHID2; j++)
        acc += longint'(wgt_h2[i*NHID2 + j]) * longint'(act_h2[j]);
      res.class_bit = (longint'({1'b0, gain_q}) * acc >= 0);
      res.out_index = IDX_W'(i);
      res.out_last  = (i == NOUT - 1);
      expected_classes.push_back(res);
    end
  endtask

  // idle draw with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // input and output monitor, predictor and checker
  always @(posedge clk_i) begin
    mlp_req_t   r;
    class_res_t exp_res;
    logic       any_acc;
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      any_acc = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        r.op    = s_axis_tuser;
        r.last  = s_axis_tlast;
        r.layer = s_axis_tdata[1:0];
        r.row   = s_axis_tdata[7:2];
        r.col   = s_axis_tdata[13:8];
        r.value = s_axis_tdata[29:14];
        classify_request(r);
        accepted_reqs++;
        any_acc = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        any_acc = 1'b1;
        if (expected_classes.size() == 0) begin
          $error("result with nothing expected: index %0d", m_axis_tdata[6:1]);
          errors++;
        end else begin
          exp_res = expected_classes.pop_front();
          if (m_axis_tdata[0] !== exp_res.class_bit) begin
            $error("class_bit: expected %0d, actual %0d", exp_res.class_bit,
                   m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[6:1] !== exp_res.out_index) begin
            $error("out_index: expected %0d, actual %0d", exp_res.out_index,
                   m_axis_tdata[6:1]);
            errors++;
          end
          if (m_axis_tlast !== exp_res.out_last) begin
            $error("out_last: expected %0d, actual %0d", exp_res.out_last,
                   m_axis_tlast);
            errors++;
          end
        end
      end
      stall_cycles <= any_acc ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // request driver
  int tx_gap;
  int tx_calm;
  always @(negedge clk_i) begin
    mlp_req_t r;
    logic     nxt_valid;
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      nxt_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        s_axis_tuser <= r.op;
        s_axis_tlast <= r.last;
        s_axis_tdata <= {2'b00, r.value, r.col, r.row, r.layer};
        nxt_valid = 1'b1;
        tx_gap = draw_gap(tx_calm);
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // result receiver with random stalls and one long hold-off once results flow
  int   rx_gap;
  int   rx_calm;
  int   rx_hold_left;
  logic rx_hold_done;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_req && !rx_hold_done && m_axis_tvalid) begin
        rx_hold_done = 1'b1;
        rx_hold_left = RX_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (out_taken) begin
        rx_gap = draw_gap(rx_calm);
        m_axis_tready <= (rx_gap == 0);
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= (rx_gap == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(logic op, logic [1:0] layer, int row, int col,
                           int value, logic last);
    mlp_req_t r;
    r.op    = op;
    r.layer = layer;
    r.row   = IDX_W'(row);
    r.col   = IDX_W'(col);
    r.value = VAL_W'(value);
    r.last  = last;
    pending_reqs.push_back(r);
    queued_reqs++;
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // one sample: a few weight updates, noise now and then, features closed by last
  task automatic queue_sample();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0: queue_req(OP_LOAD, LYR_IN, $urandom_range(0, NHID1-1),
                     $urandom_range(0, NIN-1), pick_value(), 1'b0);
        1: queue_req(OP_LOAD, LYR_H1, $urandom_range(0, NHID2-1),
                     $urandom_range(0, NHID1-1), pick_value(), 1'b0);
        default: queue_req(OP_LOAD, LYR_H2, $urandom_range(0, NOUT-1),
                           $urandom_range(0, NHID2-1), pick_value(), 1'b0);
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      // random load: an out-of-range address is ignored, last on a weight has no effect
      queue_req(OP_LOAD, 2'($urandom_range(0, 3)), $urandom_range(0, 63),
                $urandom_range(0, 63), pick_value(), 1'($urandom_range(0, 1)));
    end
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++)
      queue_req(OP_FEAT, 2'($urandom_range(0, 3)), $urandom_range(0, 63),
                $urandom_range(0, NIN-1), pick_value(), 1'b0);
    queue_req(OP_FEAT, 2'($urandom_range(0, 3)), $urandom_range(0, 63),
              $urandom_range(0, NIN-1), pick_value(), 1'b1);
  endtask

  task automatic random_phase(int n_reqs);
    int target;
    target = queued_reqs + n_reqs;
    while (queued_reqs < target) queue_sample();
  endtask

  task automatic wait_idle();
    while (accepted_reqs != queued_reqs || expected_classes.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_q = g;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    rx_hold_req = 1'b0;
    rx_hold_done = 1'b0;
    rx_hold_left = 0;
    rx_gap = 0;
    rx_calm = 0;
    tx_gap = 0;
    tx_calm = 0;
    stall_cycles = 0;
    queued_reqs = 0;
    accepted_reqs = 0;
    errors = 0;
    gain_q = GAIN_RESET;
    fill_logistic_lut();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every weight store and the feature vector before any sample runs
    for (int r = 0; r < NHID1; r++)
      for (int c = 0; c < NIN; c++) queue_req(OP_LOAD, LYR_IN, r, c, pick_value(), 1'b0);
    for (int r = 0; r < NHID2; r++)
      for (int c = 0; c < NHID1; c++) queue_req(OP_LOAD, LYR_H1, r, c, pick_value(), 1'b0);
    for (int r = 0; r < NOUT; r++)
      for (int c = 0; c < NHID2; c++) queue_req(OP_LOAD, LYR_H2, r, c, pick_value(), 1'b0);
    for (int c = 0; c < NIN; c++) queue_req(OP_FEAT, LYR_IN, 0, c, pick_value(), 1'b0);

    // directed: extremes, ignored loads, last on a weight, sample triggers
    queue_req(OP_LOAD, LYR_IN, 0, 0, 32767, 1'b0);
    queue_req(OP_LOAD, LYR_IN, NHID1-1, NIN-1, -32768, 1'b0);
    queue_req(OP_LOAD, LYR_H1, NHID2-1, NHID1-1, 32767, 1'b0);
    queue_req(OP_LOAD, LYR_H2, NOUT-1, NHID2-1, -32768, 1'b0);
    queue_req(OP_FEAT, LYR_IN, 0, 0, 32767, 1'b0);
    queue_req(OP_FEAT, LYR_IN, 0, NIN-1, -32768, 1'b1);
    queue_req(OP_LOAD, 2'd3, 0, 0, 12345, 1'b0);
    queue_req(OP_LOAD, LYR_IN, 63, 5, 777, 1'b0);
    queue_req(OP_LOAD, LYR_H1, 3, 63, 777, 1'b0);
    queue_req(OP_LOAD, LYR_H1, 40, 3, 777, 1'b0);
    queue_req(OP_LOAD, LYR_H2, 8, 0, 777, 1'b0);
    queue_req(OP_LOAD, LYR_H2, 0, 32, 777, 1'b0);
    queue_req(OP_LOAD, LYR_IN, 1, 1, -1, 1'b1);
    queue_req(OP_FEAT, 2'd3, 63, 7, 0, 1'b1);
    queue_req(OP_FEAT, LYR_IN, 0, 8, 1, 1'b1);

    // receiver holds off at the first result while requests keep coming
    rx_hold_req = 1'b1;
    random_phase(110);
    wait_idle();

    write_gain(GAIN_W'(1));
    random_phase(60);
    wait_idle();

    write_gain(GAIN_W'(32767));
    random_phase(60);
    wait_idle();

    write_gain(GAIN_W'(0));
    random_phase(40);
    wait_idle();

    write_gain(GAIN_W'($urandom_range(1, 32767)));
    random_phase(100);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_classes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
